@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SVA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define SVA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

@@ src/slbm_pkg.sv @@
`default_nettype none

package slbm_pkg;

    typedef enum logic [1:0] {
        OP_CPU_RD = 2'd0,
        OP_CPU_WR = 2'd1,
        OP_PPU_RD = 2'd2,
        OP_PPU_WR = 2'd3
    } t_op;

    typedef enum logic {
        CFG_PRG_COUNT = 1'b0,
        CFG_CHR_COUNT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_op         op;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic        ram_select;
        logic [12:0] ram_offset;
        logic [17:0] rom_addr;
        logic [1:0]  mirror_mode;
    } t_out;

    localparam logic [4:0] CONTROL_RESET   = 5'h1C;
    localparam logic [4:0] PRG_COUNT_RESET = 5'd2;
    localparam logic [5:0] CHR_COUNT_RESET = 6'd0;

    // load targets, from address bits 14:13
    localparam logic [1:0] TGT_CONTROL  = 2'd0;
    localparam logic [1:0] TGT_CHR_LOW  = 2'd1;
    localparam logic [1:0] TGT_CHR_HIGH = 2'd2;
    localparam logic [1:0] TGT_PRG      = 2'd3;

    // PRG modes, control bits 3:2
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

    localparam logic [2:0] SHIFT_LAST = 3'd4;

endpackage

`default_nettype wire

@@ src/serial_loaded_bank_mapper_top.sv @@
// An accepted item's result is registered and shows in the output register in the next cycle.
// Throughput: one item per cycle; input stalls only while a result is held back.
// Each access is decoded in the accepting cycle; its bank state update is lost if a config write comes then.
// Reset (i_rst_n low, synchronous): bank state to power-up values, output empty.
// Configuration writes are registered and win over an access's bank update; the config port is always ready.
`default_nettype none

module serial_loaded_bank_mapper_top (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire slbm_pkg::t_in      i_in,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output slbm_pkg::t_out          o_out,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire slbm_pkg::t_cfg_index i_cfg_index,
    input  wire [5:0]               i_cfg_data
);

    logic [4:0] r_prg_count;
    logic [5:0] r_chr_count;
    logic [4:0] r_shift;
    logic [2:0] r_count;
    logic [4:0] r_control;
    logic [4:0] r_chr_low;
    logic [4:0] r_chr_high;
    logic [3:0] r_prg_low;
    logic [3:0] r_prg_high;
    logic [2:0] r_prg_wide;
    logic       r_out_valid;
    slbm_pkg::t_out r_out;

    logic [4:0] n_shift;
    logic [2:0] n_count;
    logic [4:0] n_control;
    logic [4:0] n_chr_low;
    logic [4:0] n_chr_high;
    logic [3:0] n_prg_low;
    logic [3:0] n_prg_high;
    logic [2:0] n_prg_wide;
    slbm_pkg::t_out n_out;

    logic       accept;
    logic       cpu_side;
    logic       in_ram;
    logic       in_rom;
    logic [4:0] shifted;
    logic [4:0] last_full;
    logic [3:0] prg_bank;
    logic [17:0] prg_addr;
    logic [17:0] chr_addr;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign last_full = r_prg_count - 5'd1;
    assign shifted   = {i_in.data[0], r_shift[4:1]};
    assign cpu_side  = (i_in.op == slbm_pkg::OP_CPU_RD) || (i_in.op == slbm_pkg::OP_CPU_WR);
    assign in_ram    = (i_in.addr[15:13] == 3'b011);
    assign in_rom    = i_in.addr[15];

    // PRG translation: 16K banks in mode bit 3, else one 32K bank
    assign prg_bank = i_in.addr[14] ? r_prg_high : r_prg_low;
    always_comb begin
        if (r_control[3]) begin
            prg_addr = {prg_bank, i_in.addr[13:0]};
        end else begin
            prg_addr = {r_prg_wide, i_in.addr[14:0]};
        end
    end

    // CHR translation; no ROM banks means RAM, address passes through
    always_comb begin
        if (r_chr_count == 6'd0) begin
            chr_addr = {2'b00, i_in.addr};
        end else if (r_control[4]) begin
            chr_addr = {1'b0, (i_in.addr[12] ? r_chr_high : r_chr_low), i_in.addr[11:0]};
        end else begin
            // 8K mode adds the full 13-bit offset onto a 4K-aligned base
            chr_addr = {1'b0, r_chr_low, 12'd0} + {5'd0, i_in.addr[12:0]};
        end
    end

    always_comb begin
        n_shift    = r_shift;
        n_count    = r_count;
        n_control  = r_control;
        n_chr_low  = r_chr_low;
        n_chr_high = r_chr_high;
        n_prg_low  = r_prg_low;
        n_prg_high = r_prg_high;
        n_prg_wide = r_prg_wide;

        n_out             = '0;
        if (cpu_side) begin
            if (in_ram) begin
                n_out.hit        = 1'b1;
                n_out.ram_select = 1'b1;
                n_out.ram_offset = i_in.addr[12:0];
            end else if (in_rom) begin
                if (i_in.op == slbm_pkg::OP_CPU_RD) begin
                    n_out.hit      = 1'b1;
                    n_out.rom_addr = prg_addr;
                end else if (i_in.data[7]) begin
                    n_shift   = 5'd0;
                    n_count   = 3'd0;
                    n_control = r_control | 5'h0C;
                end else if (r_count == slbm_pkg::SHIFT_LAST) begin
                    n_shift = 5'd0;
                    n_count = 3'd0;
                    case (i_in.addr[14:13])
                        slbm_pkg::TGT_CONTROL: begin
                            n_control = shifted;
                        end
                        slbm_pkg::TGT_CHR_LOW: begin
                            n_chr_low = r_control[4] ? shifted : {shifted[4:1], 1'b0};
                        end
                        slbm_pkg::TGT_CHR_HIGH: begin
                            if (r_control[4]) begin
                                n_chr_high = shifted;
                            end
                        end
                        default: begin
                            case (r_control[3:2])
                                slbm_pkg::PRG_MODE_FIX_FIRST: begin
                                    n_prg_low  = 4'd0;
                                    n_prg_high = shifted[3:0];
                                end
                                slbm_pkg::PRG_MODE_FIX_LAST: begin
                                    n_prg_low  = shifted[3:0];
                                    n_prg_high = last_full[3:0];
                                end
                                default: begin
                                    n_prg_wide = shifted[3:1];
                                end
                            endcase
                        end
                    endcase
                end else begin
                    n_shift = shifted;
                    n_count = r_count + 3'd1;
                end
            end
        end else if (i_in.addr[15:13] == 3'b000) begin
            n_out.hit = 1'b1;
            if (i_in.op == slbm_pkg::OP_PPU_RD) begin
                n_out.rom_addr = chr_addr;
            end else if (r_chr_count == 6'd0) begin
                n_out.rom_addr = {2'b00, i_in.addr};
            end
        end
        n_out.mirror_mode = n_control[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count <= slbm_pkg::PRG_COUNT_RESET;
            r_chr_count <= slbm_pkg::CHR_COUNT_RESET;
            r_shift     <= 5'd0;
            r_count     <= 3'd0;
            r_control   <= slbm_pkg::CONTROL_RESET;
            r_chr_low   <= 5'd0;
            r_chr_high  <= 5'd0;
            r_prg_low   <= 4'd0;
            r_prg_high  <= 4'(slbm_pkg::PRG_COUNT_RESET - 5'd1);
            r_prg_wide  <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    slbm_pkg::CFG_PRG_COUNT: begin
                        r_prg_count <= i_cfg_data[4:0];
                        r_prg_high  <= 4'(i_cfg_data[4:0] - 5'd1);
                    end
                    slbm_pkg::CFG_CHR_COUNT: begin
                        r_chr_count <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end else if (accept) begin
                r_shift    <= n_shift;
                r_count    <= n_count;
                r_control  <= n_control;
                r_chr_low  <= n_chr_low;
                r_chr_high <= n_chr_high;
                r_prg_low  <= n_prg_low;
                r_prg_high <= n_prg_high;
                r_prg_wide <= n_prg_wide;
            end
            if (o_in_ready) begin
                r_out_valid <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

@@ src/slbm_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module slbm_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input wire slbm_pkg::t_out o_out
);

    // a held result stays put
    `SVA_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> o_out_valid)
    `SVA_ASSERT(a_out_stable, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> $stable(o_out))
    // every accepted item shows its result on the next cycle
    `SVA_ASSERT(a_one_cycle, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> o_out_valid)
    // no intake while the output register is full and blocked
    `SVA_ASSERT(a_backpressure, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |-> !o_in_ready)
    `SVA_ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> !o_out_valid)

endmodule

bind serial_loaded_bank_mapper_top slbm_checker u_slbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
